@@ sv/hsl_to_rgb_converter_core_assert.svh @@
// assertion macros used by the bound SVA checker
`ifndef HSL_TO_RGB_CONVERTER_CORE_ASSERT_SVH
`define HSL_TO_RGB_CONVERTER_CORE_ASSERT_SVH

// same-cycle implication
`define HSL2RGB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hsl2rgb: implication violated");

// consequence one pipeline latency after the antecedent
`define HSL2RGB_ASSERT_LATER(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> ##OutLatency (cons)) \
    else $error("hsl2rgb: delayed implication violated");

// condition never seen out of reset
`define HSL2RGB_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("hsl2rgb: forbidden condition seen");

`endif

@@ sv/hsl2rgb_pkg.sv @@
package hsl2rgb_pkg;

  localparam int FracBits   = 12;
  localparam int HueW       = 16;
  localparam int SatW       = 14;
  localparam int ChanW      = 8;
  localparam int UnitW      = FracBits + 1;
  localparam int HueFull    = 23040;
  localparam int HueSector  = 3840;
  localparam int WrapW      = 15;
  localparam int RampW      = 12;
  localparam int CnW        = 2 * FracBits + 1;
  localparam int BaseW      = 2 * FracBits + 2;
  localparam int NumW       = 2 * FracBits + 13;
  localparam int ScaleShift = 2 * FracBits + 8;
  localparam int OutLatency = 5;

  localparam logic [UnitW-1:0] One = {1'b1, {FracBits{1'b0}}};

  // 60-degree sectors, named by the color span they cover
  typedef enum logic [2:0] {
    SecRedYel = 3'd0,
    SecYelGrn = 3'd1,
    SecGrnCyn = 3'd2,
    SecCynBlu = 3'd3,
    SecBluMag = 3'd4,
    SecMagRed = 3'd5
  } sector_e;

  typedef struct packed {
    sector_e          sector;
    logic [RampW-1:0] ramp;
  } hue_info_t;

  function automatic logic [UnitW-1:0] clamp_unit(logic signed [SatW-1:0] v);
    logic [UnitW-1:0] r;
    if (v[SatW-1]) begin
      r = '0;
    end else if (int'(v) > (1 << FracBits)) begin
      r = One;
    end else begin
      r = UnitW'(v);
    end
    return r;
  endfunction

endpackage

@@ sv/hsl2rgb_hue_sector.sv @@
module hsl2rgb_hue_sector import hsl2rgb_pkg::*; (
  input  logic [WrapW-1:0] hue_i,
  output hue_info_t        info_o
);

  sector_e          sec;
  logic [WrapW-1:0] base;
  logic [RampW-1:0] rem;

  always_comb begin
    sec  = SecRedYel;
    base = '0;
    priority if (hue_i >= WrapW'(5 * HueSector)) begin
      sec  = SecMagRed;
      base = WrapW'(5 * HueSector);
    end else if (hue_i >= WrapW'(4 * HueSector)) begin
      sec  = SecBluMag;
      base = WrapW'(4 * HueSector);
    end else if (hue_i >= WrapW'(3 * HueSector)) begin
      sec  = SecCynBlu;
      base = WrapW'(3 * HueSector);
    end else if (hue_i >= WrapW'(2 * HueSector)) begin
      sec  = SecGrnCyn;
      base = WrapW'(2 * HueSector);
    end else if (hue_i >= WrapW'(HueSector)) begin
      sec  = SecYelGrn;
      base = WrapW'(HueSector);
    end else begin
      sec  = SecRedYel;
      base = '0;
    end
    rem = RampW'(hue_i - base);
    info_o.sector = sec;
    // rising ramp in even sectors, falling in odd ones
    info_o.ramp   = sec[0] ? (RampW'(HueSector) - rem) : rem;
  end

endmodule

@@ sv/hsl_to_rgb_converter_core.sv @@
// channel  dir  signals                                  handshake
// input    in   hue_i, saturation_i, lightness_i         start / busy
// result   out  red_o, green_o, blue_o                   valid_o strobe, one cycle
//
// five register stages: wrap and clamp, chroma multiply, ramp multiply,
// channel select and sum, scale by 255.
// one pixel per clock; the result strobe is the end of the valid chain v1_q to v5_q,
// which runs alongside the data stages.
// busy stays low: the pipeline never stalls, the receiver cannot hold off.
// reset clears only the valid bits; data registers are not reset.
module hsl_to_rgb_converter_core import hsl2rgb_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [HueW-1:0]  hue_i,
  input  logic signed [SatW-1:0]  saturation_i,
  input  logic signed [SatW-1:0]  lightness_i,
  output logic                    valid_o,
  output logic [ChanW-1:0]        red_o,
  output logic [ChanW-1:0]        green_o,
  output logic [ChanW-1:0]        blue_o
);

  function automatic logic [ChanW-1:0] to_byte(logic [NumW-1:0] n);
    logic [NumW+4:0]            scaled;
    logic [NumW+4-ScaleShift:0] top;
    logic [ChanW-1:0]           r;
    // 255 / (15 * 2^(2F+8)) reduces to 17 / 2^(2F+8)
    scaled = {n, 4'b0} + (NumW+5)'(n);
    top    = scaled[NumW+4:ScaleShift];
    if (|top[NumW+4-ScaleShift:ChanW]) begin
      r = '1;
    end else begin
      r = top[ChanW-1:0];
    end
    return r;
  endfunction

  logic v1_q, v2_q, v3_q, v4_q, v5_q;

  // stage 1: hue wrap, clamps
  logic signed [HueW:0] hx, hw;
  logic [WrapW-1:0]     hue1_d, hue1_q;
  logic [UnitW-1:0]     sat1_q, lit1_q;

  always_comb begin
    hx = {hue_i[HueW-1], hue_i};
    priority if (hx < -(HueW+1)'(HueFull)) begin
      hw = hx + (HueW+1)'(2 * HueFull);
    end else if (hx < 0) begin
      hw = hx + (HueW+1)'(HueFull);
    end else if (hx >= (HueW+1)'(HueFull)) begin
      hw = hx - (HueW+1)'(HueFull);
    end else begin
      hw = hx;
    end
    hue1_d = WrapW'(hw);
  end

  always_ff @(posedge clk_i) begin
    hue1_q <= hue1_d;
    sat1_q <= clamp_unit(saturation_i);
    lit1_q <= clamp_unit(lightness_i);
  end

  // stage 2: sector and ramp, chroma numerator
  hue_info_t                hinfo;
  hue_info_t                hinfo2_q;
  logic signed [UnitW+1:0]  dl;
  logic [UnitW:0]           dabs;
  logic [UnitW-1:0]         span;
  logic [CnW-1:0]           cn2_d, cn2_q;
  logic [UnitW-1:0]         lit2_q;

  hsl2rgb_hue_sector u_hue_sector (
    .hue_i  (hue1_q),
    .info_o (hinfo)
  );

  always_comb begin
    dl    = $signed({1'b0, lit1_q, 1'b0}) - $signed({2'b0, One});
    dabs  = dl[UnitW+1] ? (UnitW+1)'(-dl) : (UnitW+1)'(dl);
    span  = One - UnitW'(dabs);
    cn2_d = CnW'(span) * CnW'(sat1_q);
  end

  always_ff @(posedge clk_i) begin
    hinfo2_q <= hinfo;
    cn2_q    <= cn2_d;
    lit2_q   <= lit1_q;
  end

  // stage 3: chroma, ramp product, offset terms
  logic [BaseW-1:0] base3;
  logic [NumW-1:0]  cc3_q, cx3_q, bm3_q;
  sector_e          sec3_q;

  always_comb begin
    base3 = (BaseW'(lit2_q) << (FracBits + 1)) - BaseW'(cn2_q);
  end

  always_ff @(posedge clk_i) begin
    cc3_q  <= (NumW'(cn2_q) << 12) - (NumW'(cn2_q) << 8);
    cx3_q  <= NumW'(cn2_q) * NumW'(hinfo2_q.ramp);
    bm3_q  <= (NumW'(base3) << 11) - (NumW'(base3) << 7);
    sec3_q <= hinfo2_q.sector;
  end

  // stage 4: order the components by sector and add the offset
  logic [NumW-1:0] r4, g4, b4;
  logic [NumW-1:0] nr4_q, ng4_q, nb4_q;

  always_comb begin
    unique case (sec3_q)
      SecRedYel: begin r4 = cc3_q; g4 = cx3_q; b4 = '0;    end
      SecYelGrn: begin r4 = cx3_q; g4 = cc3_q; b4 = '0;    end
      SecGrnCyn: begin r4 = '0;    g4 = cc3_q; b4 = cx3_q; end
      SecCynBlu: begin r4 = '0;    g4 = cx3_q; b4 = cc3_q; end
      SecBluMag: begin r4 = cx3_q; g4 = '0;    b4 = cc3_q; end
      default:   begin r4 = cc3_q; g4 = '0;    b4 = cx3_q; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    nr4_q <= r4 + bm3_q;
    ng4_q <= g4 + bm3_q;
    nb4_q <= b4 + bm3_q;
  end

  // stage 5: scale to bytes
  always_ff @(posedge clk_i) begin
    red_o   <= to_byte(nr4_q);
    green_o <= to_byte(ng4_q);
    blue_o  <= to_byte(nb4_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v1_q <= start && !busy;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  assign busy    = 1'b0;
  assign valid_o = v5_q;

endmodule

@@ sv/hsl2rgb_checker.sv @@
`include "hsl_to_rgb_converter_core_assert.svh"

module hsl2rgb_checker import hsl2rgb_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   start,
  input logic                   busy,
  input logic signed [HueW-1:0] hue_i,
  input logic signed [SatW-1:0] saturation_i,
  input logic signed [SatW-1:0] lightness_i,
  input logic                   valid_o,
  input logic [ChanW-1:0]       red_o,
  input logic [ChanW-1:0]       green_o,
  input logic [ChanW-1:0]       blue_o
);

  logic unused_hue;
  logic beat_in;
  logic black_px;
  logic gray_px;

  assign unused_hue = ^hue_i;
  assign beat_in    = start && !busy;
  assign black_px   = (red_o == '0) && (green_o == '0) && (blue_o == '0);
  assign gray_px    = (red_o == green_o) && (green_o == blue_o);

  `HSL2RGB_ASSERT_NEVER(a_never_busy, busy)
  `HSL2RGB_ASSERT_LATER(a_beat_latency, beat_in, valid_o)
  `HSL2RGB_ASSERT_IMP(a_no_stray_beat, valid_o, $past(beat_in, OutLatency))
  `HSL2RGB_ASSERT_LATER(a_dark_is_black, beat_in && lightness_i[SatW-1], black_px)
  `HSL2RGB_ASSERT_LATER(a_gray_unsaturated, beat_in && saturation_i[SatW-1], gray_px)

endmodule

bind hsl_to_rgb_converter_core hsl2rgb_checker u_hsl2rgb_checker (.*);

@@ tb/hsl_to_rgb_checker.sv @@
`timescale 1ns / 1ps

module hsl_to_rgb_checker import hsl2rgb_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic                   busy_i,
  input  logic signed [HueW-1:0] hue_i,
  input  logic signed [SatW-1:0] saturation_i,
  input  logic signed [SatW-1:0] lightness_i,
  input  logic                   valid_i,
  input  logic [ChanW-1:0]       red_i,
  input  logic [ChanW-1:0]       green_i,
  input  logic [ChanW-1:0]       blue_i,
  output int                     fail_count_o,
  output int                     pending_o
);

  typedef struct {
    logic signed [HueW-1:0] hue;
    logic signed [SatW-1:0] sat;
    logic signed [SatW-1:0] light;
    logic [ChanW-1:0]       red;
    logic [ChanW-1:0]       green;
    logic [ChanW-1:0]       blue;
  } pixel_t;

  pixel_t expected_rgb_q[$];
  int     mismatch_count = 0;
  int     pending_count  = 0;

  assign fail_count_o = mismatch_count;
  assign pending_o    = pending_count;

  function automatic logic [ChanW-1:0] scale_channel(longint num, longint den);
    longint v;
    v = (num * 255) / den;
    if (v > 255) v = 255;
    return ChanW'(v);
  endfunction

  // all terms are exact integers over den = 2 * unit^2 * sector width
  function automatic pixel_t predict_rgb(logic signed [HueW-1:0] hue,
                                         logic signed [SatW-1:0] sat,
                                         logic signed [SatW-1:0] light);
    longint  unit, h, s, l, d, chroma, ramp, den, cv, xv, mv, r, g, b;
    sector_e sec;
    pixel_t  px;
    unit = longint'(1) << FracBits;
    h = longint'(hue) % HueFull;
    if (h < 0) h += HueFull;
    s = (sat < 0) ? 0 : ((longint'(sat) > unit) ? unit : longint'(sat));
    l = (light < 0) ? 0 : ((longint'(light) > unit) ? unit : longint'(light));
    d = 2 * l - unit;
    if (d < 0) d = -d;
    chroma = (unit - d) * s;
    ramp = (h % (2 * HueSector)) - HueSector;
    if (ramp < 0) ramp = -ramp;
    ramp = HueSector - ramp;
    den = 2 * unit * unit * HueSector;
    cv = chroma * 2 * HueSector;
    xv = chroma * ramp * 2;
    mv = (2 * l * unit - chroma) * HueSector;
    sec = sector_e'(h / HueSector);
    case (sec)
      SecRedYel: begin r = cv; g = xv; b = 0;  end
      SecYelGrn: begin r = xv; g = cv; b = 0;  end
      SecGrnCyn: begin r = 0;  g = cv; b = xv; end
      SecCynBlu: begin r = 0;  g = xv; b = cv; end
      SecBluMag: begin r = xv; g = 0;  b = cv; end
      default: begin   r = cv; g = 0;  b = xv; end
    endcase
    px.hue   = hue;
    px.sat   = sat;
    px.light = light;
    px.red   = scale_channel(r + mv, den);
    px.green = scale_channel(g + mv, den);
    px.blue  = scale_channel(b + mv, den);
    return px;
  endfunction

  always @(posedge clk_i) begin : check_beats
    pixel_t want;
    if (rst_ni) begin
      if (valid_i) begin
        if (expected_rgb_q.size() == 0) begin
          if (mismatch_count < 10)
            $display("%0t: unexpected result r=%0d g=%0d b=%0d",
                     $realtime, red_i, green_i, blue_i);
          mismatch_count++;
        end else begin
          want = expected_rgb_q.pop_front();
          if (red_i !== want.red || green_i !== want.green || blue_i !== want.blue) begin
            if (mismatch_count < 10)
              $display("%0t: hsl (%0d,%0d,%0d) expected rgb %0d %0d %0d, got %0d %0d %0d",
                       $realtime, want.hue, want.sat, want.light,
                       want.red, want.green, want.blue, red_i, green_i, blue_i);
            mismatch_count++;
          end
        end
      end
      // input beat accepted at this edge
      if (start_i && !busy_i)
        expected_rgb_q.push_back(predict_rgb(hue_i, saturation_i, lightness_i));
    end
    pending_count <= expected_rgb_q.size();
  end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import hsl2rgb_pkg::*;

  localparam int NumRandom   = 450;
  localparam int CycleLimit  = 100000;
  localparam int DrainCycles = OutLatency + 8;

  logic                   clk   = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   start = 1'b0;
  logic                   busy;
  logic signed [HueW-1:0] hue   = '0;
  logic signed [SatW-1:0] sat   = '0;
  logic signed [SatW-1:0] light = '0;
  logic                   valid;
  logic [ChanW-1:0]       red, green, blue;
  int                     fail_count, pending;
  int                     cycle_count = 0;
  int                     burst_left  = 16;

  always #1 clk = ~clk;

  hsl_to_rgb_converter_core i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .start        (start),
    .busy         (busy),
    .hue_i        (hue),
    .saturation_i (sat),
    .lightness_i  (light),
    .valid_o      (valid),
    .red_o        (red),
    .green_o      (green),
    .blue_o       (blue)
  );

  hsl_to_rgb_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .start_i      (start),
    .busy_i       (busy),
    .hue_i        (hue),
    .saturation_i (sat),
    .lightness_i  (light),
    .valid_i      (valid),
    .red_i        (red),
    .green_i      (green),
    .blue_i       (blue),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // sender runs in bursts, with a gap of idle cycles between them
  task automatic send_pixel(input int h, input int s, input int l);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    start <= 1'b1;
    hue   <= HueW'(h);
    sat   <= SatW'(s);
    light <= SatW'(l);
    do @(posedge clk); while (busy);
  endtask

  function automatic int pick_unit();
    int v;
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4:  v = int'($urandom_range(0, 1 << SatW) ) - (1 << (SatW - 1));
      5, 6, 7:        v = int'($urandom_range(0, 5));
      8, 9:           v = (1 << FracBits) - 3 + int'($urandom_range(0, 5));
      10:             v = -(1 << (SatW - 1));
      11:             v = (1 << (SatW - 1)) - 1;
      default:        v = int'($urandom_range(0, 1 << FracBits));
    endcase
    return v;
  endfunction

  initial begin
    int h;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // sector starts and ends, hue wrap from both sides
    for (int k = 0; k < 6; k++) send_pixel(k * HueSector, 4096, 2048);
    send_pixel(HueSector - 1, 4096, 2048);
    send_pixel(HueFull - 1, 4096, 2048);
    send_pixel(-1, 4096, 2048);
    send_pixel(-32768, 4096, 2048);
    send_pixel(32767, 4096, 2048);
    send_pixel(-HueFull, 4096, 2048);
    // saturation below zero and above one
    send_pixel(1000, -8192, 2048);
    send_pixel(1000, 8191, 2048);
    send_pixel(1000, 4097, 2048);
    send_pixel(1000, -1, 2048);
    send_pixel(1000, 0, 2048);
    // lightness clamps and the black and white ends
    send_pixel(5000, 4096, -8192);
    send_pixel(5000, 4096, 8191);
    send_pixel(5000, 4096, 4096);
    send_pixel(5000, 4096, 0);
    send_pixel(5000, 4096, 1);
    send_pixel(5000, 2048, 4095);

    for (int i = 0; i < NumRandom; i++) begin
      case ($urandom_range(0, 9))
        0, 1: h = int'($urandom_range(0, 5)) * HueSector + int'($urandom_range(0, 2)) - 1
                  - (($urandom_range(0, 1) != 0) ? HueFull : 0);
        2:    h = int'($urandom_range(0, HueFull - 1));
        default: h = int'($urandom_range(0, 65535)) - 32768;
      endcase
      send_pixel(h, pick_unit(), pick_unit());
    end
    start <= 1'b0;
    @(posedge clk);

    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ hsl_to_rgb_converter_core.f @@
+incdir+sv
sv/hsl2rgb_pkg.sv
sv/hsl2rgb_hue_sector.sv
sv/hsl_to_rgb_converter_core.sv
sv/hsl2rgb_checker.sv
tb/hsl_to_rgb_checker.sv
tb/testbench.sv
